/* sv/adsr_pkg.sv */
// Shared types and constants for the ADSR envelope amplitude block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package adsr_pkg;

    localparam int DUR_WIDTH      = 24;
    localparam int CFG_ADDR_WIDTH = 3;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_DECAY   = 3'd1,
        CFG_RELEASE = 3'd2,
        CFG_START   = 3'd3,
        CFG_SUSTAIN = 3'd4
    } t_cfg_idx;

    // Normalized durations (zero already mapped to one).
    typedef struct packed {
        logic [DUR_WIDTH-1:0] attack;
        logic [DUR_WIDTH-1:0] decay;
        logic [DUR_WIDTH-1:0] rel;
    } t_dur_cfg;

endpackage
`default_nettype wire

/* sv/adsr_envelope_amplitude.sv */
// ADSR envelope amplitude, one level per request.
// Two pipelined dividers, one bit per stage; a 4-entry queue decouples front and back.
// Throughput: one request per cycle while the output is not stalled.
// Reset: synchronous, active low; clears handshake state, loads default durations/levels.
// Depends on adsr_pkg, adsr_front, adsr_queue, adsr_back, adsr_div.
`timescale 1ns / 1ps
`default_nettype none
module adsr_envelope_amplitude
    import adsr_pkg::*;
#(
    parameter int TIME_WIDTH      = 32,
    parameter int LEVEL_FRAC_BITS = 15
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0]       i_cfg_addr,
    input  wire logic [((DUR_WIDTH > LEVEL_FRAC_BITS + 1) ? DUR_WIDTH
                        : LEVEL_FRAC_BITS + 1)-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [TIME_WIDTH-1:0]           i_now_time,
    input  wire logic [TIME_WIDTH-1:0]           i_on_time,
    input  wire logic [TIME_WIDTH-1:0]           i_off_time,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [LEVEL_FRAC_BITS:0]             o_level,
    output logic                                 o_silent
);

    localparam int TW = TIME_WIDTH;
    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int DW = DUR_WIDTH;
    localparam int QW = 1 + 2 * TW;
    localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << LEVEL_FRAC_BITS;

    logic [DW-1:0] r_attack;
    logic [DW-1:0] r_decay;
    logic [DW-1:0] r_release;
    logic [LW-1:0] r_start;
    logic [LW-1:0] r_sustain;

    t_dur_cfg      dur;
    logic [LW-1:0] s0;
    logic [LW-1:0] s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= DW'(4410);
            r_decay   <= DW'(4410);
            r_release <= DW'(8820);
            r_start   <= LEVEL_ONE;
            r_sustain <= LEVEL_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ATTACK:  r_attack  <= i_cfg_data[DW-1:0];
                CFG_DECAY:   r_decay   <= i_cfg_data[DW-1:0];
                CFG_RELEASE: r_release <= i_cfg_data[DW-1:0];
                CFG_START:   r_start   <= i_cfg_data[LW-1:0];
                CFG_SUSTAIN: r_sustain <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    assign dur.attack = (r_attack  == '0) ? DW'(1) : r_attack;
    assign dur.decay  = (r_decay   == '0) ? DW'(1) : r_decay;
    assign dur.rel    = (r_release == '0) ? DW'(1) : r_release;
    assign s0 = (r_start   > LEVEL_ONE) ? LEVEL_ONE : r_start;
    assign s1 = (r_sustain > LEVEL_ONE) ? LEVEL_ONE : r_sustain;

    logic          f_valid;
    logic          f_ready;
    logic          f_held;
    logic [TW-1:0] f_life;
    logic [TW-1:0] f_rel_age;

    logic          q_valid;
    logic          q_ready;
    logic [QW-1:0] q_data;

    adsr_front #(.TW(TW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_now_time (i_now_time),
        .i_on_time  (i_on_time),
        .i_off_time (i_off_time),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_held     (f_held),
        .o_life     (f_life),
        .o_rel_age  (f_rel_age)
    );

    adsr_queue #(.W(QW), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_held, f_life, f_rel_age}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    adsr_back #(.TW(TW), .LW(LW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_held    (q_data[QW-1]),
        .i_life    (q_data[2*TW-1:TW]),
        .i_rel_age (q_data[TW-1:0]),
        .i_dur     (dur),
        .i_s0      (s0),
        .i_s1      (s1),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_level   (o_level),
        .o_silent  (o_silent)
    );

endmodule
`default_nettype wire

/* sv/adsr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module adsr_div #(
    parameter int NW = 40,
    parameter int DW = 24,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quot,
    output logic [SW-1:0]      o_side
);

    logic          r_v    [QW];
    logic [NW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [SW-1:0] r_side [QW];

    logic          s_v    [QW];
    logic [NW-1:0] s_rem  [QW];
    logic [DW-1:0] s_den  [QW];
    logic [QW-1:0] s_q    [QW];
    logic [SW-1:0] s_side [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_stage
            localparam int K = QW - 1 - i;
            logic [NW-1:0] sh;
            logic          ge;

            if (i == 0) begin : g_first
                assign s_v[i]    = i_valid;
                assign s_rem[i]  = i_num;
                assign s_den[i]  = i_den;
                assign s_q[i]    = '0;
                assign s_side[i] = i_side;
            end else begin : g_next
                assign s_v[i]    = r_v[i-1];
                assign s_rem[i]  = r_rem[i-1];
                assign s_den[i]  = r_den[i-1];
                assign s_q[i]    = r_q[i-1];
                assign s_side[i] = r_side[i-1];
            end

            assign sh = NW'(s_den[i]) << K;
            assign ge = (s_rem[i] >= sh);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[i] <= 1'b0;
                end else if (i_en) begin
                    r_v[i] <= s_v[i];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i]  <= ge ? (s_rem[i] - sh) : s_rem[i];
                    r_den[i]  <= s_den[i];
                    r_q[i]    <= s_q[i] | (QW'(ge) << K);
                    r_side[i] <= s_side[i];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

/* sv/adsr_front.sv */
// Front stage: takes a request, forms lifetimes and the held/released class.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module adsr_front #(
    parameter int TW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [TW-1:0] i_now_time,
    input  wire logic [TW-1:0] i_on_time,
    input  wire logic [TW-1:0] i_off_time,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_held,
    output logic [TW-1:0]      o_life,
    output logic [TW-1:0]      o_rel_age
);

    logic          r_v;
    logic          r_held;
    logic [TW-1:0] r_life;
    logic [TW-1:0] r_rel_age;
    logic          held;

    assign held    = (i_on_time > i_off_time);
    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_held    <= held;
            r_life    <= held ? (i_now_time - i_on_time) : (i_off_time - i_on_time);
            r_rel_age <= i_now_time - i_off_time;
        end
    end

    assign o_valid   = r_v;
    assign o_held    = r_held;
    assign o_life    = r_life;
    assign o_rel_age = r_rel_age;

endmodule
`default_nettype wire

/* sv/adsr_queue.sv */
// Small register FIFO between the front and back parts.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module adsr_queue #(
    parameter int W     = 65,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* sv/adsr_back.sv */
// Back part: held-envelope ramp, release ramp and output register.
// Depends on adsr_pkg and adsr_div.
`timescale 1ns / 1ps
`default_nettype none
module adsr_back
    import adsr_pkg::*;
#(
    parameter int TW = 32,
    parameter int LW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_held,
    input  wire logic [TW-1:0] i_life,
    input  wire logic [TW-1:0] i_rel_age,
    input  wire t_dur_cfg      i_dur,
    input  wire logic [LW-1:0] i_s0,
    input  wire logic [LW-1:0] i_s1,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [LW-1:0]      o_level,
    output logic               o_silent
);

    localparam int DW  = DUR_WIDTH;
    localparam int XW  = (TW > DW + 1) ? TW : DW + 1;
    localparam int NW  = DW + LW;
    localparam int SW1 = 1 + LW + 1 + TW;
    localparam int SW2 = 1 + LW;

    logic en;

    // stage 1: phase select
    logic [XW-1:0] life_x;
    logic [XW-1:0] a_x;
    logic [XW-1:0] ad_x;
    logic [XW-1:0] t_x;
    logic [DW-1:0] x1;
    logic [LW-1:0] m1;
    logic [LW-1:0] base1;
    logic          sub1;
    logic [DW-1:0] den1;

    logic          r1_v;
    logic [DW-1:0] r1_x;
    logic [LW-1:0] r1_m;
    logic [LW-1:0] r1_base;
    logic          r1_sub;
    logic [DW-1:0] r1_den;
    logic          r1_held;
    logic [TW-1:0] r1_rel_age;

    // stage 2: product
    logic           r2_v;
    logic [NW-1:0]  r2_num;
    logic [DW-1:0]  r2_den;
    logic [SW1-1:0] r2_side;

    logic           d1_v;
    logic [LW-1:0]  d1_q;
    logic [SW1-1:0] d1_side;
    logic           d1_held;
    logic [LW-1:0]  d1_base;
    logic           d1_sub;
    logic [TW-1:0]  d1_rel_age;

    // stage 3: held level, release setup
    logic [XW-1:0] rt_x;
    logic [XW-1:0] ra_x;
    logic [XW-1:0] rem_x;
    logic          r3_v;
    logic [DW-1:0] r3_x;
    logic [LW-1:0] r3_lvl;
    logic          r3_held;

    // stage 4: release product
    logic           r4_v;
    logic [NW-1:0]  r4_num;
    logic [SW2-1:0] r4_side;

    logic           d2_v;
    logic [LW-1:0]  d2_q;
    logic [SW2-1:0] d2_side;

    logic          r_ov;
    logic [LW-1:0] r_level;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    assign life_x = XW'(i_life);
    assign a_x    = XW'(i_dur.attack);
    assign ad_x   = XW'(i_dur.attack) + XW'(i_dur.decay);
    assign t_x    = life_x - a_x;

    always_comb begin
        if (life_x <= a_x) begin
            x1    = life_x[DW-1:0];
            m1    = i_s0;
            base1 = '0;
            sub1  = 1'b0;
            den1  = i_dur.attack;
        end else if (life_x <= ad_x) begin
            x1    = t_x[DW-1:0];
            base1 = i_s0;
            den1  = i_dur.decay;
            if (i_s1 >= i_s0) begin
                m1   = i_s1 - i_s0;
                sub1 = 1'b0;
            end else begin
                m1   = i_s0 - i_s1;
                sub1 = 1'b1;
            end
        end else begin
            x1    = '0;
            m1    = '0;
            base1 = i_s1;
            sub1  = 1'b0;
            den1  = DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= d1_v;
            r4_v <= r3_v;
            r_ov <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x       <= x1;
            r1_m       <= m1;
            r1_base    <= base1;
            r1_sub     <= sub1;
            r1_den     <= den1;
            r1_held    <= i_held;
            r1_rel_age <= i_rel_age;

            r2_num  <= NW'(r1_x) * NW'(r1_m) + (r1_sub ? NW'(r1_den) - NW'(1) : '0);
            r2_den  <= r1_den;
            r2_side <= {r1_held, r1_base, r1_sub, r1_rel_age};

            r3_x    <= (ra_x >= rt_x) ? '0 : rem_x[DW-1:0];
            r3_lvl  <= d1_sub ? (d1_base - d1_q) : (d1_base + d1_q);
            r3_held <= d1_held;

            r4_num  <= NW'(r3_x) * NW'(r3_lvl);
            r4_side <= {r3_held, r3_lvl};

            r_level <= d2_side[SW2-1] ? d2_side[LW-1:0] : d2_q;
        end
    end

    adsr_div #(.NW(NW), .DW(DW), .QW(LW), .SW(SW1)) u_div_held (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  (r2_side),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_side)
    );

    assign {d1_held, d1_base, d1_sub, d1_rel_age} = d1_side;

    assign rt_x  = XW'(i_dur.rel);
    assign ra_x  = XW'(d1_rel_age);
    assign rem_x = rt_x - ra_x;

    adsr_div #(.NW(NW), .DW(DW), .QW(LW), .SW(SW2)) u_div_rel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_num   (r4_num),
        .i_den   (i_dur.rel),
        .i_side  (r4_side),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_side  (d2_side)
    );

    assign o_valid  = r_ov;
    assign o_level  = r_level;
    assign o_silent = (r_level == '0);

endmodule
`default_nettype wire

/* dv/adsr_envelope_amplitude_chk.sv */
// Checker for the ADSR envelope amplitude block: watches config writes and both
// request channels, predicts each level and compares in order. Depends on adsr_pkg.
`timescale 1ns / 1ps
module adsr_envelope_amplitude_chk
    import adsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_now_time,
    input  logic [31:0] i_on_time,
    input  logic [31:0] i_off_time,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_level,
    input  logic        i_silent,
    output int          o_errors,
    output int          o_pending,
    output int          o_levels_seen
);
    localparam logic [63:0] LVL_ONE = 64'd32768;

    logic [23:0] attack_q, decay_q, release_q;
    logic [15:0] start_q, sustain_q;
    logic [15:0] level_exp_q[$];

    initial begin
        o_errors = 0;
        o_levels_seen = 0;
    end

    assign o_pending = level_exp_q.size();

    function automatic logic [63:0] dur_norm(input logic [23:0] v);
        return (v == 0) ? 64'd1 : {40'd0, v};
    endfunction

    function automatic logic [63:0] lvl_sat(input logic [15:0] v);
        return ({48'd0, v} > LVL_ONE) ? LVL_ONE : {48'd0, v};
    endfunction

    function automatic logic [63:0] held_amp(input logic [63:0] life);
        logic [63:0] a, d, s0, s1, t;
        a = dur_norm(attack_q);
        d = dur_norm(decay_q);
        s0 = lvl_sat(start_q);
        s1 = lvl_sat(sustain_q);
        if (life <= a) return (life * s0) / a;
        if (life <= a + d) begin
            t = life - a;
            if (s1 >= s0) return s0 + (t * (s1 - s0)) / d;
            return s0 - (t * (s0 - s1) + d - 1) / d;
        end
        return s1;
    endfunction

    function automatic logic [15:0] envelope_level(input logic [31:0] now_t,
            input logic [31:0] on_t, input logic [31:0] off_t);
        logic [31:0] life, since_off;
        logic [63:0] rel_amp, rt, r;
        if (on_t > off_t) begin
            life = now_t - on_t;
            return 16'(held_amp({32'd0, life}));
        end
        life = off_t - on_t;
        rel_amp = held_amp({32'd0, life});
        since_off = now_t - off_t;
        r = {32'd0, since_off};
        rt = dur_norm(release_q);
        if (r >= rt) return 16'd0;
        return 16'(((rt - r) * rel_amp) / rt);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
            input logic [15:0] exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        logic [15:0] exp_lvl;
        if (!i_rst_n) begin
            attack_q  <= 24'd4410;
            decay_q   <= 24'd4410;
            release_q <= 24'd8820;
            start_q   <= 16'd32768;
            sustain_q <= 16'd32768;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_ATTACK:  attack_q  <= i_cfg_data;
                    CFG_DECAY:   decay_q   <= i_cfg_data;
                    CFG_RELEASE: release_q <= i_cfg_data;
                    CFG_START:   start_q   <= i_cfg_data[15:0];
                    CFG_SUSTAIN: sustain_q <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                level_exp_q.push_back(envelope_level(i_now_time, i_on_time, i_off_time));
            if (i_out_valid && i_out_ready) begin
                o_levels_seen++;
                if (level_exp_q.size() == 0) begin
                    report_mismatch("unexpected level", i_level, 16'd0);
                end else begin
                    exp_lvl = level_exp_q.pop_front();
                    if (i_level !== exp_lvl) report_mismatch("level", i_level, exp_lvl);
                    if (i_silent !== (exp_lvl == 0))
                        report_mismatch("silent", {15'd0, i_silent}, {15'd0, exp_lvl == 0});
                end
            end
        end
    end
endmodule

/* dv/adsr_envelope_amplitude_tb.sv */
// Testbench top for adsr_envelope_amplitude: drives config phases and random
// envelope requests with gaps and stalls; verdict from the checker. Depends on adsr_pkg.
`timescale 1ns / 1ps
module adsr_envelope_amplitude_tb;
    import adsr_pkg::*;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 60;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = 0;
    logic [23:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [31:0] now_t = 0, on_t = 0, off_t = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [15:0] level;
    logic        silent;
    int          errors, pending, levels_seen;
    int          cycles = 0;
    int          requests = 0;
    logic [23:0] cur_attack = 4410, cur_decay = 4410;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    adsr_envelope_amplitude u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_now_time(now_t), .i_on_time(on_t), .i_off_time(off_t),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_level(level), .o_silent(silent)
    );

    adsr_envelope_amplitude_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_now_time(now_t), .i_on_time(on_t), .i_off_time(off_t),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_level(level), .i_silent(silent),
        .o_errors(errors), .o_pending(pending), .o_levels_seen(levels_seen)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** adsr_envelope_amplitude: FAILED **");
            $finish;
        end
    end

    // receiver stalls, with quiet stretches
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                n = gap_len();
                repeat (n) @(posedge i_clk);
                if (n > 0) out_ready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        if (idx == CFG_ATTACK) cur_attack = val;
        if (idx == CFG_DECAY) cur_decay = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send(input logic [31:0] nw, input logic [31:0] on,
            input logic [31:0] off, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        now_t <= nw;
        on_t <= on;
        off_t <= off;
        do @(posedge i_clk); while (!in_ready);
        requests++;
    endtask

    task automatic idle_out();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // random note: mostly well-formed, lifetime spread over attack, decay, sustain and release
    task automatic random_note();
        logic [31:0] on, off, nw, span;
        int kind;
        span = cur_attack + cur_decay;
        on = $urandom();
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            off = on - $urandom_range(1, 1000);
            if (kind == 0) off = on - 1;
            nw = on + $urandom_range(0, span + span / 4 + 2);
        end else if (kind < 8) begin
            off = on + $urandom_range(0, span + 3);
            nw = off + $urandom_range(0, 20000);
        end else begin
            off = $urandom();
            nw = $urandom();
        end
        send(nw, on, off, 1'b1);
    endtask

    task automatic random_phase(input int n);
        repeat (n) random_note();
        idle_out();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: release from sustain, release end, attack and sustain with wrap, equal times
        send(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send(32'd4410, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send(32'd2205, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send(32'd8820, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send(32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0);
        send(32'd5, 32'd5, 32'd5, 1'b0);
        send(32'd100, 32'd0, 32'd4000, 1'b0);
        send(32'd12820, 32'd0, 32'd4000, 1'b0);
        send(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        idle_out();

        // zero durations, levels above one, falling decay
        write_reg(CFG_ATTACK, 24'd0);
        write_reg(CFG_DECAY, 24'd0);
        write_reg(CFG_RELEASE, 24'd0);
        write_reg(CFG_START, 24'hFFFF);
        write_reg(CFG_SUSTAIN, 24'd40000);
        send(32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send(32'd2, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send(32'd3, 32'd0, 32'd1, 1'b0);
        send(32'd1, 32'd0, 32'd1, 1'b0);
        idle_out();
        write_reg(CFG_ATTACK, 24'd3);
        write_reg(CFG_DECAY, 24'd5);
        write_reg(CFG_RELEASE, 24'd7);
        write_reg(CFG_START, 24'd32768);
        write_reg(CFG_SUSTAIN, 24'd1000);
        for (int t = 0; t < 10; t++) send(t, 32'd0, 32'hFFFF_FFFF, 1'b0);
        idle_out();

        // max durations, zero start level, then random settings
        write_reg(CFG_ATTACK, 24'hFF_FFFF);
        write_reg(CFG_DECAY, 24'hFF_FFFF);
        write_reg(CFG_RELEASE, 24'hFF_FFFF);
        write_reg(CFG_START, 24'd0);
        write_reg(CFG_SUSTAIN, 24'd32768);
        random_phase(80);
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_ATTACK, 24'((p % 2) ? $urandom_range(1, 64) : $urandom()));
            write_reg(CFG_DECAY, 24'((p % 3 == 0) ? $urandom_range(1, 64) : $urandom()));
            write_reg(CFG_RELEASE, 24'((p % 2) ? $urandom_range(1, 64) : $urandom()));
            write_reg(CFG_START, 24'((p == 5) ? 32'hFFFF : $urandom_range(0, 32768)));
            write_reg(CFG_SUSTAIN, 24'((p == 4) ? 32'd0 : $urandom_range(0, 32768)));
            random_phase(100);
        end

        $display("requests %0d, levels checked %0d, across 10 register settings",
                 requests, levels_seen);
        if (errors == 0 && pending == 0) begin
            $display("** adsr_envelope_amplitude: PASSED **");
        end else begin
            $display("** adsr_envelope_amplitude: FAILED **");
        end
        $finish;
    end
endmodule
